>>> src/tbe_pkg.sv
package tbe_pkg;

  // field widths
  localparam int SECONDS_W = 44;
  localparam int NANOS_W   = 30;
  localparam int HTYPE_W   = 3;
  localparam int LEN_W     = 3;
  localparam int FRAC_W    = 13;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_HEADER_TYPE = 1'b0;
  localparam logic [HTYPE_W-1:0] HEADER_TYPE_RESET = 3'd5;

  // arithmetic constants
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  // ceil(2^32 / 5), exact quotient for any dividend below 2^30
  localparam logic [29:0] RECIP_5    = 30'd858993460;
  localparam logic [30:0] FRAC_BIAS  = 31'd195312;
  localparam logic [18:0] FRAC_DIV   = 19'd390625;
  // floor(2^44 / 390625), estimate low by at most one
  localparam logic [25:0] RECIP_DIV  = 26'd45035996;
  localparam logic [FRAC_W-1:0] FRAC_FULL = 13'd4096;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD = 3'd7;

  typedef struct packed {
    logic [SECONDS_W-1:0] seconds;
    logic [NANOS_W-1:0]   nanoseconds;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic reduce;
    logic mul5;
    logic bias;
    logic mulr;
    logic est;
    logic corr;
    logic tail;
    logic emit_head;
    logic emit_body;
    logic last_byte;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [LEN_W-1:0] len;
  } dp_status_t;

endpackage

>>> src/timestamp_blob_encoder.sv
// channel | signals                          | word
// --------+----------------------------------+--------------------------------
// in      | in_valid, in_stall, in_data      | seconds (44b), nanoseconds (30b)
// out     | out_valid, out_stall, out_data   | out_byte (8b), last (1b)
// apb     | psel, penable, pwrite, paddr ... | header_type at byte address 0
//
// one item passes through the block in order (L = payload length, 2 to 7): an
// accept, seven steps through the shared arithmetic datapath, then the header
// and L payload words at one a cycle while the output is not stalled
// a stall on the output holds the emit sequence; the input is stalled from the
// accept until the last word has been loaded into the output register
// synchronous active-high reset returns the sequencer to idle and header_type to 5
module timestamp_blob_encoder
  import tbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [HTYPE_W-1:0] header_type;
  logic               wr_en;
  dp_cmd_t            cmd;
  dp_status_t         status;

  // register file: a single word-aligned register, paddr[2] picks the index
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_type <= HEADER_TYPE_RESET;
    end else if (wr_en && paddr[2] == REG_HEADER_TYPE) begin
      header_type <= pwdata[HTYPE_W-1:0];
    end
  end

  // reads of anything beyond the list return zero
  assign prdata = (paddr[2] == REG_HEADER_TYPE) ?
                  {{(APB_DATA_W-HTYPE_W){1'b0}}, header_type} : '0;

  // sequencer: steps the arithmetic, then emits header and payload words
  tbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: fraction by reciprocal multiplies, tail assembly, byte shifter
  tbe_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_data     (in_data),
    .header_type (header_type),
    .status      (status),
    .out_data    (out_data)
  );

endmodule

>>> src/tbe_datapath.sv
module tbe_datapath
  import tbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  in_word_t           in_data,
  input  logic [HTYPE_W-1:0] header_type,
  output dp_status_t         status,
  output out_word_t          out_data
);

  logic [SECONDS_W-1:0] secs;
  logic [NANOS_W-1:0]   nsr;
  logic [LEN_W-1:0]     len;
  logic [27:0]          q5;
  logic [30:0]          x;
  logic [FRAC_W-1:0]    est;
  logic [30:0]          qd;
  logic [FRAC_W-1:0]    frac;
  logic [55:0]          shreg;

  logic [LEN_W-1:0]     len_next;
  logic [39:0]          high_in;
  logic [59:0]          prod5;
  logic [56:0]          prodr;
  logic [31:0]          prodd;
  logic [30:0]          resid;
  logic [15:0]          tail;
  logic [55:0]          blob;
  logic [5:0]           sh;

  // payload length: two plus the bytes needed by seconds >> 4
  assign high_in = in_data.seconds[SECONDS_W-1:4];
  always_comb begin
    if (high_in[39:32] != '0) begin
      len_next = 3'd7;
    end else if (high_in[31:24] != '0) begin
      len_next = 3'd6;
    end else if (high_in[23:16] != '0) begin
      len_next = 3'd5;
    end else if (high_in[15:8] != '0) begin
      len_next = 3'd4;
    end else if (high_in[7:0] != '0) begin
      len_next = 3'd3;
    end else begin
      len_next = 3'd2;
    end
  end

  assign prod5 = 60'(nsr) * 60'(RECIP_5);
  assign prodr = 57'(x) * 57'(RECIP_DIV);
  assign prodd = 32'(est) * 32'(FRAC_DIV);
  assign resid = x - qd;
  assign tail  = {secs[3:0], 12'd0} + 16'(frac);
  assign blob  = {secs[SECONDS_W-1:4], tail};
  assign sh    = {MAX_PAYLOAD - len, 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      secs <= in_data.seconds;
      nsr  <= in_data.nanoseconds;
      len  <= len_next;
    end
    if (cmd.reduce && nsr >= NS_PER_SEC) begin
      nsr <= nsr - NS_PER_SEC;
    end
    if (cmd.mul5) begin
      q5 <= prod5[59:32];
    end
    if (cmd.bias) begin
      x <= {q5, 3'b000} + FRAC_BIAS;
    end
    if (cmd.mulr) begin
      est <= prodr[56:44];
    end
    if (cmd.est) begin
      qd <= prodd[30:0];
    end
    if (cmd.corr) begin
      frac <= (resid >= 31'(FRAC_DIV)) ? est + 13'd1 : est;
    end
    if (cmd.tail) begin
      shreg <= blob << sh;
    end
    if (cmd.emit_head) begin
      // bit 7 set, bit 6 clear, length in bits 5:3, type in bits 2:0
      out_data <= '{out_byte: {1'b1, 1'b0, len, header_type}, last: 1'b0};
    end
    if (cmd.emit_body) begin
      out_data <= '{out_byte: shreg[55:48], last: cmd.last_byte};
      shreg    <= {shreg[47:0], 8'd0};
    end
  end

  assign status.len = len;

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> (len >= 3'd2))
    else $error("payload length below two");

  a_ns_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.reduce |=> (nsr < NS_PER_SEC))
    else $error("nanoseconds not reduced below one second");

  a_est_low: assert property (@(posedge clk) disable iff (rst)
    cmd.corr |-> (x >= qd))
    else $error("quotient estimate too high");

  a_frac_max: assert property (@(posedge clk) disable iff (rst)
    cmd.corr |=> (frac <= FRAC_FULL))
    else $error("fraction above a full second");

endmodule

>>> src/tbe_ctrl.sv
module tbe_ctrl
  import tbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_MUL5,
    S_BIAS,
    S_MULR,
    S_EST,
    S_CORR,
    S_TAIL,
    S_HEAD,
    S_BODY
  } state_t;

  state_t           state;
  logic [LEN_W-1:0] cnt;
  logic             space;

  assign space    = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_in   = (state == S_IDLE) && in_valid;
    cmd.reduce    = (state == S_MOD);
    cmd.mul5      = (state == S_MUL5);
    cmd.bias      = (state == S_BIAS);
    cmd.mulr      = (state == S_MULR);
    cmd.est       = (state == S_EST);
    cmd.corr      = (state == S_CORR);
    cmd.tail      = (state == S_TAIL);
    cmd.emit_head = (state == S_HEAD) && space;
    cmd.emit_body = (state == S_BODY) && space;
    cmd.last_byte = (cnt == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.emit_head || cmd.emit_body) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MOD;
          end
        end
        S_MOD:  state <= S_MUL5;
        S_MUL5: state <= S_BIAS;
        S_BIAS: state <= S_MULR;
        S_MULR: state <= S_EST;
        S_EST:  state <= S_CORR;
        S_CORR: state <= S_TAIL;
        S_TAIL: state <= S_HEAD;
        S_HEAD: begin
          if (space) begin
            cnt   <= status.len;
            state <= S_BODY;
          end
        end
        S_BODY: begin
          if (space) begin
            cnt <= cnt - 3'd1;
            if (cnt == 3'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_BODY) |-> (cnt != '0))
    else $error("body state with no bytes left");

  a_head_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_head |=> (out_valid && state == S_BODY))
    else $error("header word not presented");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_body && cmd.last_byte) |=> (state == S_IDLE && out_valid))
    else $error("blob did not close on its last word");

endmodule
